FILE: hdl/msw_pkg.sv
// Shared types, constants and the 2^(-i/16) table of the STDP weight update unit.
// No dependencies.
package msw_pkg;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_LOAD = 10'b00_0000_0010,
        ST_RD   = 10'b00_0000_0100,
        ST_ISS  = 10'b00_0000_1000,
        ST_WAIT = 10'b00_0001_0000,
        ST_OWN  = 10'b00_0010_0000,
        ST_G    = 10'b00_0100_0000,
        ST_C    = 10'b00_1000_0000,
        ST_M    = 10'b01_0000_0000,
        ST_W    = 10'b10_0000_0000
    } state_t;

    localparam logic [2:0] CFG_PRE_GAIN     = 3'd0;
    localparam logic [2:0] CFG_PAIR_GAIN    = 3'd1;
    localparam logic [2:0] CFG_DECAY_A      = 3'd2;
    localparam logic [2:0] CFG_DECAY_B      = 3'd3;
    localparam logic [2:0] CFG_TRACE_GAIN_A = 3'd4;
    localparam logic [2:0] CFG_TRACE_GAIN_B = 3'd5;
    localparam logic [2:0] CFG_TRIGGER      = 3'd6;
    localparam logic [2:0] CFG_MAX_WEIGHT   = 3'd7;

    localparam logic ACT_SPIKE = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    localparam logic [24:0] TRACE_ONE = 25'h001_0000;
    localparam logic [24:0] TRACE_MAX = 25'h0FF_FFFF;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [47:0] X_LIMIT   = 48'h10_0000;

    function automatic logic [16:0] pow2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/msw_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module msw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/msw_decay.sv
// Five-stage trace decay pipeline: exp(-dt*rate) by 2^x table interpolation, times trace.
// Depends on msw_pkg.
module msw_decay (
    input  logic        clk,
    input  logic [31:0] dt,
    input  logic [15:0] rate,
    input  logic [23:0] trace,
    output logic [23:0] dec
);

    logic [47:0] s1_x_reg;
    logic [23:0] s1_tr_reg;
    logic [21:0] s2_y_reg;
    logic        s2_zero_reg;
    logic [23:0] s2_tr_reg;
    logic [23:0] s3_prod_reg;
    logic [16:0] s3_t0_reg;
    logic [5:0]  s3_k_reg;
    logic        s3_zero_reg;
    logic [23:0] s3_tr_reg;
    logic [16:0] s4_f_reg;
    logic [23:0] s4_tr_reg;
    logic [23:0] dec_reg;

    logic [37:0] y_full;
    logic [4:0]  ti;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [16:0] tdiff;
    logic [23:0] corr;
    logic [16:0] v;
    logic [40:0] p;

    assign y_full = 38'(s1_x_reg[20:0]) * 38'(msw_pkg::LOG2E_Q16);
    assign ti     = {1'b0, s2_y_reg[15:12]};
    assign t0     = msw_pkg::pow2_tab(ti);
    assign t1     = msw_pkg::pow2_tab(ti + 5'd1);
    assign tdiff  = t0 - t1;
    assign corr   = (s3_prod_reg + 24'd2048) >> 12;
    assign v      = s3_t0_reg - corr[16:0];
    assign p      = 41'(s4_tr_reg) * 41'(s4_f_reg) + 41'd32768;

    always_ff @(posedge clk)
    begin
        s1_x_reg    <= 48'(dt) * 48'(rate);
        s1_tr_reg   <= trace;
        s2_zero_reg <= s1_x_reg > msw_pkg::X_LIMIT;
        s2_y_reg    <= y_full[37:16];
        s2_tr_reg   <= s1_tr_reg;
        s3_prod_reg <= 24'(tdiff[11:0]) * 24'(s2_y_reg[11:0]);
        s3_t0_reg   <= t0;
        s3_k_reg    <= s2_y_reg[21:16];
        s3_zero_reg <= s2_zero_reg;
        s3_tr_reg   <= s2_tr_reg;
        s4_f_reg    <= s3_zero_reg ? 17'd0 : (v >> s3_k_reg);
        s4_tr_reg   <= s3_tr_reg;
        dec_reg     <= p[39:16];
    end

    assign dec = dec_reg;

endmodule

FILE: hdl/multiplicative_stdp_weight_update_unit.sv
// Multiplicative STDP weight update unit for the input synapses of one neuron.
// Depends on msw_pkg, msw_ram, msw_decay.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the rule registers;
//   cfg_ready is always high. Write only while the unit is idle.
//   s_axis carries one command per transfer: tuser = action (spike or load),
//   tdata = synapse index, spike time, load weight. m_axis returns each changed
//   weight; tlast marks the final result of a command.
// Sequence:
//   A load writes its weight and returns it. A spike updates its own synapse, and
//   with trigger enabled then updates every synapse in turn, each one through
//   the read / decay pipeline / multiply chain walked once per synapse.
//   One command is in flight at a time; s_tready is high only when idle.
// Reset:
//   Registers take their reset values, spike times and traces read as zero
//   through per-entry valid bits; weights are undefined until loaded.
// Stall:
//   The result sits in an output register; while m_tready is low the unit
//   holds before the next weight write-back.
module multiplicative_stdp_weight_update_unit #(
    parameter int NUM_SYNAPSES = 32,
    parameter int NUM_TRACES   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // synapse_index[4:0], spike_time[36:5], load_weight[52:37]
    input  logic [0:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_index[4:0], new_weight[20:5]
    output logic        m_tlast    // last_result
);

    localparam int AW = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SYNAPSES - 1);
    localparam bit TWO_TRACES = (NUM_TRACES > 1);

    logic signed [15:0] pre_gain_reg;
    logic signed [15:0] pair_gain_reg;
    logic [15:0]        decay_a_reg;
    logic [15:0]        decay_b_reg;
    logic signed [15:0] gain_a_reg;
    logic signed [15:0] gain_b_reg;
    logic               trigger_reg;
    logic [15:0]        max_weight_reg;

    msw_pkg::state_t state_reg, state_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          loop_reg, loop_next;
    logic [31:0]   now_reg;
    logic [15:0]   lw_reg;
    logic          trig_reg;
    logic          m_tvalid_reg;
    logic [4:0]    out_idx_reg;
    logic [15:0]   out_w_reg;
    logic          out_last_reg;

    logic [NUM_SYNAPSES-1:0] valid_reg;
    logic                    vrd_reg;

    logic [15:0]        w_reg;
    logic signed [27:0] m_reg;
    logic signed [17:0] d_reg;
    logic signed [40:0] pa_reg;
    logic signed [40:0] pb_reg;
    logic signed [26:0] c_reg;

    logic        accept;
    logic [5:0]  in_idx6;
    logic        in_range;
    logic        out_free;
    logic        emit;
    logic [5:0]  addr6;

    logic        w_we;
    logic [15:0] w_wdata;
    logic [15:0] w_rdata;
    logic        s_we;
    logic [79:0] s_wdata;
    logic [79:0] s_rdata;

    logic [31:0] last_rd;
    logic [23:0] ta_rd;
    logic [23:0] tb_rd;
    logic [31:0] dt;
    logic [23:0] dec_a;
    logic [23:0] dec_b;
    logic [24:0] nta_full;
    logic [24:0] ntb_full;
    logic [23:0] nta;
    logic [23:0] ntb;

    logic signed [15:0] gain_b_eff;
    logic signed [40:0] ga_x;
    logic signed [40:0] gb_x;
    logic signed [40:0] da_x;
    logic signed [40:0] db_x;
    logic signed [41:0] c_sum;
    logic signed [41:0] c_full;
    logic signed [43:0] gc_prod;
    logic signed [43:0] m_full;
    logic               pre_pos;
    logic               pair_pos;
    logic signed [17:0] d_pre;
    logic signed [17:0] d_pair;
    logic signed [46:0] md_prod;
    logic signed [46:0] q_full;
    logic signed [46:0] w_ext;
    logic signed [46:0] max_ext;
    logic signed [46:0] nw_full;
    logic [15:0]        nw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_gain_reg   <= '0;
            pair_gain_reg  <= '0;
            decay_a_reg    <= '0;
            decay_b_reg    <= '0;
            gain_a_reg     <= '0;
            gain_b_reg     <= '0;
            trigger_reg    <= 1'b0;
            max_weight_reg <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                msw_pkg::CFG_PRE_GAIN:     pre_gain_reg   <= cfg_data;
                msw_pkg::CFG_PAIR_GAIN:    pair_gain_reg  <= cfg_data;
                msw_pkg::CFG_DECAY_A:      decay_a_reg    <= cfg_data;
                msw_pkg::CFG_DECAY_B:      decay_b_reg    <= cfg_data;
                msw_pkg::CFG_TRACE_GAIN_A: gain_a_reg     <= cfg_data;
                msw_pkg::CFG_TRACE_GAIN_B: gain_b_reg     <= cfg_data;
                msw_pkg::CFG_TRIGGER:      trigger_reg    <= cfg_data[0];
                msw_pkg::CFG_MAX_WEIGHT:   max_weight_reg <= cfg_data;
                default:                   trigger_reg    <= trigger_reg;
            endcase
        end
    end

    assign s_tready = (state_reg == msw_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_idx6  = {1'b0, s_tdata[4:0]};
    assign in_range = in_idx6 < 6'(NUM_SYNAPSES);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = out_free &&
                      (state_reg == msw_pkg::ST_W || state_reg == msw_pkg::ST_LOAD);
    assign addr6    = 6'(addr_reg);

    // synapse memories
    assign w_we    = emit;
    assign w_wdata = (state_reg == msw_pkg::ST_LOAD) ? lw_reg : nw;
    assign s_we    = (state_reg == msw_pkg::ST_OWN);
    assign s_wdata = {now_reg, nta, ntb};

    msw_ram #(.WIDTH(16), .DEPTH(NUM_SYNAPSES), .AW(AW)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (addr_reg),
        .wdata (w_wdata),
        .raddr (addr_reg),
        .rdata (w_rdata)
    );

    msw_ram #(.WIDTH(80), .DEPTH(NUM_SYNAPSES), .AW(AW)) u_spike_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (addr_reg),
        .wdata (s_wdata),
        .raddr (addr_reg),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vrd_reg   <= 1'b0;
        end
        else
        begin
            vrd_reg <= valid_reg[addr_reg];
            if (s_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    assign last_rd = vrd_reg ? s_rdata[79:48] : 32'd0;
    assign ta_rd   = vrd_reg ? s_rdata[47:24] : 24'd0;
    assign tb_rd   = (vrd_reg && TWO_TRACES) ? s_rdata[23:0] : 24'd0;
    assign dt      = now_reg - last_rd;

    msw_decay u_decay_a (
        .clk   (clk),
        .dt    (dt),
        .rate  (decay_a_reg),
        .trace (ta_rd),
        .dec   (dec_a)
    );

    msw_decay u_decay_b (
        .clk   (clk),
        .dt    (dt),
        .rate  (decay_b_reg),
        .trace (tb_rd),
        .dec   (dec_b)
    );

    // trace refresh on own spike
    assign nta_full = msw_pkg::TRACE_ONE + 25'(dec_a);
    assign ntb_full = msw_pkg::TRACE_ONE + 25'(dec_b);
    assign nta = (nta_full > msw_pkg::TRACE_MAX) ? 24'hFF_FFFF : nta_full[23:0];
    assign ntb = !TWO_TRACES ? 24'd0 :
                 (ntb_full > msw_pkg::TRACE_MAX) ? 24'hFF_FFFF : ntb_full[23:0];

    // activity and weight step arithmetic
    assign gain_b_eff = TWO_TRACES ? gain_b_reg : 16'sd0;
    assign ga_x    = 41'(gain_a_reg);
    assign gb_x    = 41'(gain_b_eff);
    assign da_x    = 41'({1'b0, dec_a});
    assign db_x    = 41'({1'b0, dec_b});
    assign c_sum   = 42'(pa_reg) + 42'(pb_reg);
    assign c_full  = (c_sum + 42'sd16384) >>> 15;
    assign gc_prod = 44'(pair_gain_reg) * 44'(c_reg);
    assign m_full  = (gc_prod + 44'sd16384) >>> 15;

    assign pre_pos  = pre_gain_reg > 16'sd0;
    assign pair_pos = pair_gain_reg > 16'sd0;
    assign d_pre    = pre_pos ? (18'({2'b0, max_weight_reg}) - 18'({2'b0, w_reg}))
                              : 18'({2'b0, w_reg});
    assign d_pair   = pair_pos ? (18'({2'b0, max_weight_reg}) - 18'({2'b0, w_reg}))
                               : 18'({2'b0, w_reg});

    assign md_prod = 47'(m_reg) * 47'(d_reg);
    assign q_full  = (md_prod + 47'sd32768) >>> 16;
    assign w_ext   = 47'({1'b0, w_reg});
    assign max_ext = 47'({1'b0, max_weight_reg});
    assign nw_full = w_ext + q_full;
    assign nw      = (nw_full < 47'sd0) ? 16'd0 :
                     (nw_full > max_ext) ? max_weight_reg : nw_full[15:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg  <= s_tdata[36:5];
            lw_reg   <= s_tdata[52:37];
            trig_reg <= trigger_reg;
        end
        if (state_reg == msw_pkg::ST_ISS)
        begin
            w_reg <= w_rdata;
        end
        if (state_reg == msw_pkg::ST_OWN)
        begin
            m_reg <= 28'(pre_gain_reg) <<< 1;
            d_reg <= d_pre;
        end
        if (state_reg == msw_pkg::ST_G)
        begin
            pa_reg <= ga_x * da_x;
            pb_reg <= gb_x * db_x;
        end
        if (state_reg == msw_pkg::ST_C)
        begin
            c_reg <= c_full[26:0];
        end
        if (state_reg == msw_pkg::ST_M)
        begin
            m_reg <= m_full[27:0];
            d_reg <= d_pair;
        end
        if (emit)
        begin
            out_idx_reg  <= addr6[4:0];
            out_w_reg    <= w_wdata;
            out_last_reg <= (state_reg == msw_pkg::ST_LOAD) ? 1'b1 :
                            loop_reg ? (addr_reg == LAST_ADDR) : !trig_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        loop_next  = loop_reg;
        case (state_reg)
            msw_pkg::ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    addr_next  = in_idx6[AW-1:0];
                    loop_next  = 1'b0;
                    state_next = (s_tuser[0] == msw_pkg::ACT_LOAD) ? msw_pkg::ST_LOAD
                                                                   : msw_pkg::ST_RD;
                end
            end
            msw_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = msw_pkg::ST_IDLE;
                end
            end
            msw_pkg::ST_RD:
            begin
                state_next = msw_pkg::ST_ISS;
            end
            msw_pkg::ST_ISS:
            begin
                cnt_next   = 2'd3;
                state_next = msw_pkg::ST_WAIT;
            end
            msw_pkg::ST_WAIT:
            begin
                if (cnt_reg == 2'd0)
                begin
                    state_next = loop_reg ? msw_pkg::ST_G : msw_pkg::ST_OWN;
                end
                else
                begin
                    cnt_next = cnt_reg - 2'd1;
                end
            end
            msw_pkg::ST_OWN:
            begin
                state_next = msw_pkg::ST_W;
            end
            msw_pkg::ST_G:
            begin
                state_next = msw_pkg::ST_C;
            end
            msw_pkg::ST_C:
            begin
                state_next = msw_pkg::ST_M;
            end
            msw_pkg::ST_M:
            begin
                state_next = msw_pkg::ST_W;
            end
            msw_pkg::ST_W:
            begin
                if (out_free)
                begin
                    if (!loop_reg)
                    begin
                        if (trig_reg)
                        begin
                            loop_next  = 1'b1;
                            addr_next  = '0;
                            state_next = msw_pkg::ST_RD;
                        end
                        else
                        begin
                            state_next = msw_pkg::ST_IDLE;
                        end
                    end
                    else if (addr_reg == LAST_ADDR)
                    begin
                        state_next = msw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + AW'(1);
                        state_next = msw_pkg::ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = msw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= msw_pkg::ST_IDLE;
            cnt_reg      <= '0;
            addr_reg     <= '0;
            loop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            addr_reg  <= addr_next;
            loop_reg  <= loop_next;
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_w_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == msw_pkg::ST_W || state_reg == msw_pkg::ST_LOAD))
        else $error("result appeared without a write-back");

    a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msw_pkg::ST_W) |-> (nw <= max_weight_reg))
        else $error("updated weight above max_weight");

    a_spike_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range && s_tuser[0] == msw_pkg::ACT_SPIKE) |=>
        (state_reg == msw_pkg::ST_RD))
        else $error("spike transfer did not start a synapse read");
`endif

endmodule

FILE: tb/sv/tb_multiplicative_stdp_weight_update_unit.sv
// Self-checking testbench for the multiplicative STDP weight update unit.
// Holds its own predictor of weights, traces and spike times; needs msw_pkg and the RTL.
`timescale 1ns / 100ps

module tb_multiplicative_stdp_weight_update_unit;

    localparam int NSYN = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int unsigned EXP2_FRAC [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    typedef struct {
        logic [4:0]  index;
        logic [15:0] weight;
        logic        last;
    } weight_report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // synapse_index[4:0], spike_time[36:5], load_weight[52:37]
    logic [0:0]  s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // out_index[4:0], new_weight[20:5]
    logic        m_tlast;   // last_result

    logic [15:0] rule_reg [8];
    logic [15:0] weight_mem [NSYN];
    logic [31:0] last_spike_mem [NSYN];
    logic [23:0] trace_a_mem [NSYN];
    logic [23:0] trace_b_mem [NSYN];
    weight_report_t pending_weights [$];

    int          errors;
    int          items_sent;
    int          results_seen;
    int          idle_cycles;
    bit          quiet;
    logic [31:0] tick_now;
    int          rx_stall;

    multiplicative_stdp_weight_update_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint round_shift(longint p, int s);
        return (p + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint decay_factor(logic [31:0] dt, logic [15:0] rate);
        longint unsigned x;
        longint unsigned y;
        int unsigned     k;
        int unsigned     f;
        int unsigned     i;
        int unsigned     r;
        int unsigned     v;
        x = dt;
        x = x * rate;
        if (x > 64'h10_0000)
            return 0;
        y = (x * 94548) >> 16;
        k = 32'(y >> 16);
        f = 32'(y & 64'hFFFF);
        i = f >> 12;
        r = f & 32'hFFF;
        v = EXP2_FRAC[i] - (((EXP2_FRAC[i] - EXP2_FRAC[i + 1]) * r + 2048) >> 12);
        if (k >= 32)
            return 0;
        return v >> k;
    endfunction

    function automatic longint decay_trace(logic [23:0] tr, longint fac);
        return (longint'(tr) * fac + 32768) >> 16;
    endfunction

    function automatic logic [15:0] step_weight(logic [15:0] w, longint g, longint c);
        longint mx;
        longint d;
        longint nw;
        mx = rule_reg[msw_pkg::CFG_MAX_WEIGHT];
        d = (g > 0) ? mx - longint'(w) : longint'(w);
        nw = longint'(w) + round_shift(round_shift(g * c, 15) * d, 16);
        if (nw < 0)
            nw = 0;
        if (nw > mx)
            nw = mx;
        return nw[15:0];
    endfunction

    task automatic push_weight(logic [4:0] idx, logic [15:0] w, logic last);
        weight_report_t e;
        e.index = idx;
        e.weight = w;
        e.last = last;
        pending_weights.push_back(e);
    endtask

    task automatic predict_command(logic act, logic [4:0] idx, logic [31:0] t,
                                   logic [15:0] lw);
        longint nt;
        longint sum;
        longint act_sum;
        logic [31:0] dt;
        bit trig;
        trig = rule_reg[msw_pkg::CFG_TRIGGER][0];
        if (act == msw_pkg::ACT_LOAD)
        begin
            weight_mem[idx] = lw;
            push_weight(idx, lw, 1'b1);
            return;
        end
        dt = t - last_spike_mem[idx];
        nt = 65536 + decay_trace(trace_a_mem[idx],
                                 decay_factor(dt, rule_reg[msw_pkg::CFG_DECAY_A]));
        trace_a_mem[idx] = (nt > 24'hFFFFFF) ? 24'hFFFFFF : nt[23:0];
        nt = 65536 + decay_trace(trace_b_mem[idx],
                                 decay_factor(dt, rule_reg[msw_pkg::CFG_DECAY_B]));
        trace_b_mem[idx] = (nt > 24'hFFFFFF) ? 24'hFFFFFF : nt[23:0];
        last_spike_mem[idx] = t;
        weight_mem[idx] = step_weight(weight_mem[idx],
                                      longint'($signed(rule_reg[msw_pkg::CFG_PRE_GAIN])),
                                      65536);
        push_weight(idx, weight_mem[idx], !trig);
        if (trig)
        begin
            for (int j = 0; j < NSYN; j++)
            begin
                dt = t - last_spike_mem[j];
                sum = longint'($signed(rule_reg[msw_pkg::CFG_TRACE_GAIN_A]))
                    * decay_trace(trace_a_mem[j],
                                  decay_factor(dt, rule_reg[msw_pkg::CFG_DECAY_A]))
                    + longint'($signed(rule_reg[msw_pkg::CFG_TRACE_GAIN_B]))
                    * decay_trace(trace_b_mem[j],
                                  decay_factor(dt, rule_reg[msw_pkg::CFG_DECAY_B]));
                act_sum = round_shift(sum, 15);
                weight_mem[j] = step_weight(weight_mem[j],
                                            longint'($signed(rule_reg[msw_pkg::CFG_PAIR_GAIN])),
                                            act_sum);
                push_weight(j[4:0], weight_mem[j], j == NSYN - 1);
            end
        end
    endtask

    task automatic report_mismatch(string what);
        errors++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task automatic send_command(logic act, logic [4:0] idx, logic [31:0] t,
                                logic [15:0] lw);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {3'b0, lw, t, idx};
        do
            @(posedge clk);
        while (!s_tready);
        predict_command(act, idx, t, lw);
        items_sent++;
    endtask

    task automatic spike_at(logic [4:0] idx, int unsigned adv);
        tick_now = tick_now + adv;
        send_command(msw_pkg::ACT_SPIKE, idx, tick_now, 16'h0);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // writes all eight rule registers; drains first so the unit is idle
    task automatic load_rules(logic [15:0] pre, logic [15:0] pair, logic [15:0] ra,
                              logic [15:0] rb, logic [15:0] ga, logic [15:0] gb,
                              logic trig, logic [15:0] mx);
        logic [15:0] vals [8];
        vals = '{pre, pair, ra, rb, ga, gb, {15'b0, trig}, mx};
        drain();
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            rule_reg[i] = (i == msw_pkg::CFG_TRIGGER) ? (vals[i] & 16'h1) : vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick16(bit sgn);
        case ($urandom_range(0, 5))
            0: return sgn ? 16'h8000 : 16'h0000;
            1: return sgn ? 16'h7FFF : 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom());
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    always @(posedge clk)
    begin
        weight_report_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_weights.size() == 0)
                report_mismatch($sformatf("unexpected result idx=%0d w=%0d",
                                          m_tdata[4:0], m_tdata[20:5]));
            else
            begin
                e = pending_weights.pop_front();
                if (m_tdata[4:0] !== e.index)
                    report_mismatch($sformatf("out_index %0d, want %0d",
                                              m_tdata[4:0], e.index));
                if (m_tdata[20:5] !== e.weight)
                    report_mismatch($sformatf("new_weight idx %0d: %0d, want %0d",
                                              e.index, m_tdata[20:5], e.weight));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last_result idx %0d: %0b, want %0b",
                                              e.index, m_tlast, e.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            m_tready <= 1'b1;
            rx_stall <= 0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            m_tready <= (rx_stall == 1);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rx_stall <= $urandom_range(1, 18);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("multiplicative_stdp_weight_update_unit: mismatch");
            $finish;
        end
    end

    task automatic test_weight_load;
        load_rules(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'hFFFF);
        for (int i = 0; i < NSYN; i++)
            send_command(msw_pkg::ACT_LOAD, i[4:0], $urandom(),
                         (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                         (i == 2) ? 16'h5555 : (i == 3) ? 16'hAAAA : 16'($urandom()));
    endtask

    task automatic test_own_step;
        load_rules(16'h7FFF, 16'h0, 16'h0100, 16'h0010, 16'h0, 16'h0, 1'b0, 16'hFFFF);
        spike_at(5'd0, 3);
        spike_at(5'd1, 0);
        spike_at(5'd4, 1);
        load_rules(16'h8000, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b0, 16'hFFFF);
        spike_at(5'd1, 7);
        spike_at(5'd31, 100);
        spike_at(5'd31, 0);
    endtask

    task automatic test_triggered;
        load_rules(16'h1000, 16'h7FFF, 16'h0200, 16'h0040, 16'h7FFF, 16'h8000, 1'b1,
                   16'hC000);
        spike_at(5'd2, 5);
        spike_at(5'd9, 20);
        load_rules(16'hF000, 16'h8000, 16'h0020, 16'h0800, 16'h4000, 16'h7FFF, 1'b1,
                   16'h0000);
        spike_at(5'd3, 2);
    endtask

    task automatic test_time_backward;
        load_rules(16'h2000, 16'h4000, 16'h0001, 16'h0001, 16'h7FFF, 16'h7FFF, 1'b1,
                   16'hFFFF);
        tick_now = 32'h0000_1000;
        spike_at(5'd6, 0);
        tick_now = 32'h0000_0010;
        spike_at(5'd6, 0);
    endtask

    task automatic test_above_max;
        load_rules(16'h4000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h1000);
        send_command(msw_pkg::ACT_LOAD, 5'd7, tick_now, 16'hF000);
        spike_at(5'd7, 1);
        send_command(msw_pkg::ACT_LOAD, 5'd8, tick_now, 16'hFFFF);
        load_rules(16'hC000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'h1000);
        spike_at(5'd8, 1);
    endtask

    // zero decay: repeated spikes on one synapse pile its traces up to the ceiling
    task automatic test_trace_saturation;
        load_rules(16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 16'hFFFF);
        for (int i = 0; i < 260; i++)
            spike_at(5'd12, $urandom_range(0, 50));
        load_rules(16'h0100, 16'h7FFF, 16'h0, 16'h0, 16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF);
        spike_at(5'd12, 1);
        spike_at(5'd13, 1);
    endtask

    task automatic test_random_phase(int n);
        logic [4:0] idx;
        bit trig;
        trig = ($urandom_range(0, 2) == 0);
        load_rules(pick16(1), pick16(1), pick_rate(), pick_rate(), pick16(1), pick16(1),
                   trig, pick16(0));
        for (int i = 0; i < n; i++)
        begin
            idx = 5'($urandom());
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send_command(msw_pkg::ACT_LOAD, idx, $urandom(), pick16(0));
                3:
                begin
                    tick_now = $urandom();
                    spike_at(idx, 0);
                end
                4:
                    spike_at(idx, $urandom_range(1000, 100000));
                default:
                    spike_at(idx, $urandom_range(0, 300));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        quiet = 1'b0;
        tick_now = '0;
        rule_reg = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF};
        for (int i = 0; i < NSYN; i++)
        begin
            weight_mem[i] = '0;
            last_spike_mem[i] = '0;
            trace_a_mem[i] = '0;
            trace_b_mem[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_weight_load();
        test_own_step();
        test_triggered();
        test_time_backward();
        test_above_max();
        test_trace_saturation();
        for (int p = 0; p < 5; p++)
            test_random_phase(30);
        quiet = 1'b1;
        test_random_phase(30);

        drain();
        repeat (30) @(posedge clk);
        if (pending_weights.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_weights.size()));
        $display("Covered loads, own and triggered steps, backward time, trace ceiling,");
        $display("%0d commands and %0d weight results checked", items_sent, results_seen);
        if (errors == 0)
            $display("multiplicative_stdp_weight_update_unit: match");
        else
            $display("multiplicative_stdp_weight_update_unit: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hdl/msw_pkg.sv
hdl/msw_ram.sv
hdl/msw_decay.sv
hdl/multiplicative_stdp_weight_update_unit.sv
tb/sv/tb_multiplicative_stdp_weight_update_unit.sv
